/* hdl/bba_pkg.sv */
// ----------------------------------------------------------------------------
// bba_pkg
// shared types, codes and constants of the bitmap block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

    // field widths
    localparam int BLK_W       = 12;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int TOTAL_W     = 13;
    localparam int WORD_BITS   = 32;
    localparam int BIT_IDX_W   = 5;

    // block numbers are 12 bits, so at most this many blocks are reachable
    localparam int FIELD_BLOCKS = 4096;
    localparam int FIELD_WORDS  = FIELD_BLOCKS / WORD_BITS;
    localparam int MAP_ADDR_W   = 7;

    // parameter defaults
    localparam int DEF_MAX_BLOCKS        = 4096;
    localparam int DEF_FIRST_ALLOCATABLE = 3;

    // register file
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int REG_IDX_W   = PADDR_W - 2;
    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'd4096;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_TOTAL_BLOCKS = 1'b0
    } t_reg_idx;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_QUERY = 2'd2
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_REJECT = 2'd2
    } t_status;

    // one access request to the bitmap memory
    typedef struct packed {
        logic                  rd_en;
        logic [MAP_ADDR_W-1:0] rd_addr;
        logic                  wr_en;
        logic [MAP_ADDR_W-1:0] wr_addr;
        logic [WORD_BITS-1:0]  wr_data;
    } t_map_req;

endpackage

/* hdl/bba_if.sv */
// ----------------------------------------------------------------------------
// bba_if
// valid/ready channels for allocator requests and results
// ----------------------------------------------------------------------------
interface bba_item_if;
    import bba_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BLK_W-1:0]  block_number;

    modport source (output valid, output kind, output block_number, input ready);
    modport sink   (input valid, input kind, input block_number, output ready);
endinterface

interface bba_result_if;
    import bba_pkg::*;

    logic                valid;
    logic                ready;
    logic [BLK_W-1:0]    result_block;
    logic                block_free;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output result_block, output block_free, output status,
                    input ready);
    modport sink   (input valid, input result_block, input block_free, input status,
                    output ready);
endinterface

/* hdl/bba_map_ram.sv */
// ----------------------------------------------------------------------------
// bba_map_ram
// free bitmap memory, one read and one write port, registered read data
// ----------------------------------------------------------------------------
module bba_map_ram #(
    parameter int DEPTH  = bba_pkg::FIELD_WORDS,
    parameter int ADDR_W = bba_pkg::MAP_ADDR_W
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bba_pkg::t_map_req              i_req,
    output logic [bba_pkg::WORD_BITS-1:0]  o_rd_data
);
    import bba_pkg::*;

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]     r_valid;
    logic [WORD_BITS-1:0] r_rd_data;
    logic                 r_rd_valid;

    // words never written since reset read as all used
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr[ADDR_W-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr[ADDR_W-1:0]] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data  <= r_mem[i_req.rd_addr[ADDR_W-1:0]];
            r_rd_valid <= r_valid[i_req.rd_addr[ADDR_W-1:0]];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

/* hdl/bitmap_block_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit disk block allocator over a free bitmap (set bit = free block).
// Each request transaction gives exactly one result transaction. Allocate
// returns the lowest free block from FIRST_ALLOCATABLE up to the block limit
// minus one (limit = min of total_blocks, MAX_BLOCKS and 4096) and marks it
// used, or reports full. Free marks a block free; block 0 and blocks at or
// above the limit are rejected. Query reports whether a block is free.
// After reset every block is used; software frees blocks to build the map.
// The map sits in one memory of 32-bit words with a single read port, so
// allocate scans one word per cycle, at most ceil(limit/32) words. Free and
// query read the block's word, then write it back or report; rejected or
// out-of-range requests are answered straight from idle. Only one request
// is in flight at a time. There is no clearing pass after reset: a valid bit
// per word makes unwritten words read as all used. total_blocks sits at byte
// address 0 of the APB port; software must write it only while the block is
// idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module bitmap_block_allocator #(
    parameter int MAX_BLOCKS        = bba_pkg::DEF_MAX_BLOCKS,
    parameter int FIRST_ALLOCATABLE = bba_pkg::DEF_FIRST_ALLOCATABLE
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // apb configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bba_pkg::PADDR_W-1:0]   paddr,
    input  logic [bba_pkg::PDATA_W-1:0]   pwdata,
    output logic [bba_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    // request and result channels
    bba_item_if.sink                      i_item,
    bba_result_if.source                  o_result
);
    import bba_pkg::*;

    // map geometry: words past the 12-bit block range are never addressed
    localparam int MAP_WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int USED_WORDS = (MAP_WORDS < FIELD_WORDS) ? MAP_WORDS : FIELD_WORDS;
    localparam int AW         = $clog2(USED_WORDS);
    localparam int MAX_LIM    = (MAX_BLOCKS < FIELD_BLOCKS) ? MAX_BLOCKS : FIELD_BLOCKS;
    localparam int FIRST_WORD = FIRST_ALLOCATABLE / WORD_BITS;
    localparam int FIRST_BIT  = FIRST_ALLOCATABLE % WORD_BITS;

    localparam logic [TOTAL_W-1:0]   MAX_LIM_V     = TOTAL_W'(MAX_LIM);
    localparam logic [TOTAL_W-1:0]   FIRST_LIM_V   = TOTAL_W'(FIRST_ALLOCATABLE);
    localparam logic [AW-1:0]        FIRST_WORD_V  = AW'(FIRST_WORD);
    localparam logic [WORD_BITS-1:0] FIRST_MASK    = {WORD_BITS{1'b1}} << FIRST_BIT;

    // one-hot controller states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_FREE = 4'b0010,
        S_QRY  = 4'b0100,
        S_SCAN = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    logic [TOTAL_W-1:0]   r_total;
    logic [BLK_W-1:0]     r_blk, n_blk;
    logic [AW-1:0]        r_widx, n_widx;
    logic                 r_out_valid, n_out_valid;
    logic [BLK_W-1:0]     r_out_block, n_out_block;
    logic                 r_out_free, n_out_free;
    t_status              r_out_status, n_out_status;

    t_map_req             map_req;
    logic [WORD_BITS-1:0] map_word;

    logic [TOTAL_W-1:0]   lim;
    logic [TOTAL_W-1:0]   lim_m1;
    logic [AW-1:0]        last_word;
    logic [WORD_BITS-1:0] hi_mask;
    logic [WORD_BITS-1:0] lo_mask;
    logic [WORD_BITS-1:0] scan_bits;
    logic                 scan_hit;
    logic [BIT_IDX_W-1:0] scan_pos;
    logic                 out_slot;
    logic                 in_accept;
    logic                 cfg_write;
    logic                 blk_in_range;

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (t_reg_idx'(paddr[PADDR_W-1:2]) == REG_TOTAL_BLOCKS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= TOTAL_RESET;
        end else if (cfg_write) begin
            r_total <= pwdata[TOTAL_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (t_reg_idx'(paddr[PADDR_W-1:2]) == REG_TOTAL_BLOCKS) begin
            prdata = PDATA_W'(r_total);
        end
    end

    // ------------------------------------------------------------------
    // bitmap memory
    // ------------------------------------------------------------------
    bba_map_ram #(
        .DEPTH  (USED_WORDS),
        .ADDR_W (AW)
    ) u_map_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (map_req),
        .o_rd_data (map_word)
    );

    // ------------------------------------------------------------------
    // limit and scan window of the current word
    // ------------------------------------------------------------------
    assign lim       = (r_total > MAX_LIM_V) ? MAX_LIM_V : r_total;
    assign lim_m1    = lim - TOTAL_W'(1);
    assign last_word = lim_m1[BIT_IDX_W +: AW];

    // first word drops blocks below the first allocatable one,
    // last word drops blocks at or past the limit
    assign lo_mask   = (r_widx == FIRST_WORD_V) ? FIRST_MASK : {WORD_BITS{1'b1}};
    assign hi_mask   = (r_widx == last_word)
                       ? ({WORD_BITS{1'b1}} >> (BIT_IDX_W'(WORD_BITS - 1) - lim_m1[4:0]))
                       : {WORD_BITS{1'b1}};
    assign scan_bits = map_word & lo_mask & hi_mask;
    assign scan_hit  = |scan_bits;

    // lowest set bit of the window
    always_comb begin
        scan_pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (scan_bits[i]) begin
                scan_pos = BIT_IDX_W'(i);
            end
        end
    end

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    // the result register can take a new value when empty or being drained
    assign out_slot        = !r_out_valid || o_result.ready;
    assign i_item.ready    = (r_state == S_IDLE) && out_slot;
    assign in_accept       = i_item.valid && i_item.ready;
    assign blk_in_range    = {1'b0, i_item.block_number} < lim;

    assign o_result.valid        = r_out_valid;
    assign o_result.result_block = r_out_block;
    assign o_result.block_free   = r_out_free;
    assign o_result.status       = r_out_status;

    // ------------------------------------------------------------------
    // controller: read, modify, write back
    // ------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_blk        = r_blk;
        n_widx       = r_widx;
        n_out_valid  = r_out_valid;
        n_out_block  = r_out_block;
        n_out_free   = r_out_free;
        n_out_status = r_out_status;
        map_req      = '0;

        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_blk = i_item.block_number;
                    case (t_kind'(i_item.kind))
                        KIND_ALLOC: begin
                            if (lim <= FIRST_LIM_V) begin
                                // nothing allocatable below the limit
                                n_out_valid  = 1'b1;
                                n_out_block  = '0;
                                n_out_free   = 1'b0;
                                n_out_status = ST_FULL;
                            end else begin
                                n_widx          = FIRST_WORD_V;
                                map_req.rd_en   = 1'b1;
                                map_req.rd_addr = MAP_ADDR_W'(FIRST_WORD_V);
                                n_state         = S_SCAN;
                            end
                        end
                        KIND_FREE: begin
                            if ((i_item.block_number == '0) || !blk_in_range) begin
                                n_out_valid  = 1'b1;
                                n_out_block  = i_item.block_number;
                                n_out_free   = 1'b0;
                                n_out_status = ST_REJECT;
                            end else begin
                                map_req.rd_en   = 1'b1;
                                map_req.rd_addr =
                                    MAP_ADDR_W'(i_item.block_number[BIT_IDX_W +: AW]);
                                n_state         = S_FREE;
                            end
                        end
                        KIND_QUERY: begin
                            if (!blk_in_range) begin
                                // out of range reads as not free
                                n_out_valid  = 1'b1;
                                n_out_block  = i_item.block_number;
                                n_out_free   = 1'b0;
                                n_out_status = ST_OK;
                            end else begin
                                map_req.rd_en   = 1'b1;
                                map_req.rd_addr =
                                    MAP_ADDR_W'(i_item.block_number[BIT_IDX_W +: AW]);
                                n_state         = S_QRY;
                            end
                        end
                        default: begin
                            // unknown kind
                            n_out_valid  = 1'b1;
                            n_out_block  = i_item.block_number;
                            n_out_free   = 1'b0;
                            n_out_status = ST_REJECT;
                        end
                    endcase
                end
            end

            S_FREE: begin
                if (out_slot) begin
                    map_req.wr_en   = 1'b1;
                    map_req.wr_addr = MAP_ADDR_W'(r_blk[BIT_IDX_W +: AW]);
                    map_req.wr_data = map_word
                                      | (WORD_BITS'(1) << r_blk[BIT_IDX_W-1:0]);
                    n_out_valid     = 1'b1;
                    n_out_block     = r_blk;
                    n_out_free      = 1'b0;
                    n_out_status    = ST_OK;
                    n_state         = S_IDLE;
                end
            end

            S_QRY: begin
                if (out_slot) begin
                    n_out_valid  = 1'b1;
                    n_out_block  = r_blk;
                    n_out_free   = map_word[r_blk[BIT_IDX_W-1:0]];
                    n_out_status = ST_OK;
                    n_state      = S_IDLE;
                end
            end

            S_SCAN: begin
                if (scan_hit) begin
                    if (out_slot) begin
                        // claim the lowest free block of this word
                        map_req.wr_en   = 1'b1;
                        map_req.wr_addr = MAP_ADDR_W'(r_widx);
                        map_req.wr_data = map_word & ~(WORD_BITS'(1) << scan_pos);
                        n_out_valid     = 1'b1;
                        n_out_block     = BLK_W'({MAP_ADDR_W'(r_widx), scan_pos});
                        n_out_free      = 1'b0;
                        n_out_status    = ST_OK;
                        n_state         = S_IDLE;
                    end
                end else if (r_widx == last_word) begin
                    if (out_slot) begin
                        n_out_valid  = 1'b1;
                        n_out_block  = '0;
                        n_out_free   = 1'b0;
                        n_out_status = ST_FULL;
                        n_state      = S_IDLE;
                    end
                end else begin
                    // fetch the next word, data arrives next cycle
                    n_widx          = r_widx + AW'(1);
                    map_req.rd_en   = 1'b1;
                    map_req.rd_addr = MAP_ADDR_W'(r_widx + AW'(1));
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk        <= n_blk;
        r_widx       <= n_widx;
        r_out_block  <= n_out_block;
        r_out_free   <= n_out_free;
        r_out_status <= n_out_status;
    end

`ifndef NO_ASSERTIONS
    // the map is only written back at the end of a free or an allocate
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        map_req.wr_en |-> (r_state == S_FREE || r_state == S_SCAN))
        else $error("bitmap written outside free or allocate");

    // the scan never runs past the word that holds the last block
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_widx <= last_word))
        else $error("allocate scan past block limit");

    // a finished allocate hands out a block inside the allowed window
    a_alloc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && n_state == S_IDLE && scan_hit)
        |=> (r_out_status == ST_OK) && ({1'b0, r_out_block} >= FIRST_LIM_V)
            && ({1'b0, r_out_block} < lim))
        else $error("allocated block outside range");
`endif

endmodule

/* verif/bitmap_block_allocator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator_tb
// Self-checking bench for the first-fit bitmap allocator. A shadow copy of the
// free bitmap and of total_blocks predicts every result transaction, which is
// then compared field by field in arrival order. A short directed part covers
// disk full, rejected frees, unknown kinds and the small-limit case. A random
// part then walks through several total_blocks settings, with random idling
// on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_tb;
    import bba_pkg::*;

    localparam int                 HOLD_CYCLES  = 400;
    localparam int                 SETTLE_CYCLES = 4;
    localparam int                 DRAIN_CYCLES = 16;
    localparam logic [KIND_W-1:0]  KIND_UNKNOWN = 2'd3;
    localparam logic [PADDR_W-1:0] TOTAL_ADDR   = {REG_TOTAL_BLOCKS, 2'b00};

    // fields of one result transaction
    typedef struct packed {
        logic [BLK_W-1:0] blk;
        logic             is_free;
        t_status          st;
    } t_reply;

    // shadow of the allocator: free bitmap, block count, replies still owed
    class bitmap_shadow;
        bit [FIELD_BLOCKS-1:0] free_bits;
        logic [TOTAL_W-1:0]    total;
        t_reply                owed[$];
        int                    mismatches;
        int                    checked;
        int                    granted;
        int                    full_seen;
        int                    rejected;

        function void set_total(logic [TOTAL_W-1:0] value);
            total = value;
        endfunction

        function int outstanding();
            return owed.size();
        endfunction

        // first-fit allocation, free and query against the shadow bitmap
        function t_reply predict_reply(logic [KIND_W-1:0] kind, logic [BLK_W-1:0] blk);
            t_reply      r;
            int unsigned lim;
            lim = total;
            if (lim > DEF_MAX_BLOCKS) lim = DEF_MAX_BLOCKS;
            if (lim > FIELD_BLOCKS) lim = FIELD_BLOCKS;
            r.blk     = blk;
            r.is_free = 1'b0;
            r.st      = ST_OK;
            case (kind)
                KIND_ALLOC: begin
                    r.blk = '0;
                    r.st  = ST_FULL;
                    for (int unsigned n = DEF_FIRST_ALLOCATABLE; n < lim; n++) begin
                        if (free_bits[n]) begin
                            free_bits[n] = 1'b0;
                            r.blk        = n[BLK_W-1:0];
                            r.st         = ST_OK;
                            break;
                        end
                    end
                end
                KIND_FREE: begin
                    if (blk == 0 || blk >= lim) r.st = ST_REJECT;
                    else free_bits[blk] = 1'b1;
                end
                KIND_QUERY: r.is_free = (blk < lim) && free_bits[blk];
                default: r.st = ST_REJECT;
            endcase
            return r;
        endfunction

        function void note_request(logic [KIND_W-1:0] kind, logic [BLK_W-1:0] blk);
            t_reply r;
            r = predict_reply(kind, blk);
            if (kind == KIND_ALLOC && r.st == ST_OK) granted++;
            if (r.st == ST_FULL) full_seen++;
            if (r.st == ST_REJECT) rejected++;
            owed.push_back(r);
        endfunction

        function void check_reply(t_reply got);
            t_reply exp;
            checked++;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("error: unexpected result blk=%0d free=%0b st=%0d",
                             got.blk, got.is_free, got.st);
                return;
            end
            exp = owed.pop_front();
            if (got.blk !== exp.blk || got.is_free !== exp.is_free || got.st !== exp.st) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("error: result mismatch exp blk=%0d free=%0b st=%0d",
                             exp.blk, exp.is_free, exp.st,
                             ", got blk=%0d free=%0b st=%0d",
                             got.blk, got.is_free, got.st);
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    bba_item_if   item_ch ();
    bba_result_if result_ch ();

    bitmap_shadow shadow = new();

    // idle percentages per channel, changed by the stimulus as the run goes on
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    // long receiver hold-off: asked for by the stimulus, counted by the receiver
    bit hold_req      = 1'b0;
    int hold_left     = 0;
    int items_sent    = 0;
    int cfg_errors    = 0;
    int phases_run    = 0;

    bitmap_block_allocator u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // check every result transaction against the oldest prediction
    always @(posedge i_clk) begin
        t_reply got;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            got.blk     = result_ch.result_block;
            got.is_free = result_ch.block_free;
            got.st      = t_status'(result_ch.status);
            shadow.check_reply(got);
        end
    end

    // hang guard, far above the slowest legal run
    initial begin
        #(64'd4_000_000);
        $display("error: timeout with %0d results still owed", shadow.outstanding());
        $display("status: fail");
        $finish;
    end

    // offer one request transaction and note it once the handshake completes
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [BLK_W-1:0] blk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.kind         <= kind;
        item_ch.block_number <= blk;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        shadow.note_request(kind, blk);
        items_sent++;
    endtask

    // drop valid and wait until every owed result is back
    task automatic wait_settled();
        item_ch.valid <= 1'b0;
        while (shadow.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // apb write: setup cycle, then access cycle with pready tied high
    task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // apb read, data taken in the access cycle and compared with the shadow
    task automatic cfg_read_check(input logic [PADDR_W-1:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[TOTAL_W-1:0] !== shadow.total) begin
            cfg_errors++;
            $display("error: total_blocks read exp %0d got %0d", shadow.total,
                     prdata[TOTAL_W-1:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // new block count, only with nothing in flight
    task automatic set_total_blocks(input int value);
        wait_settled();
        cfg_write(TOTAL_ADDR, PDATA_W'(value));
        shadow.set_total(TOTAL_W'(value));
        cfg_read_check(TOTAL_ADDR);
        phases_run++;
    endtask

    // block numbers mostly inside the limit, some near zero, at its edge or anywhere
    function automatic logic [BLK_W-1:0] pick_block(input int lim);
        int r;
        int b;
        r = $urandom_range(0, 99);
        if (r < 70 && lim > 0) b = $urandom_range(0, lim - 1);
        else if (r < 80) b = $urandom_range(0, 4);
        else if (r < 90) b = lim - 1 + $urandom_range(0, 2);
        else b = $urandom_range(0, FIELD_BLOCKS - 1);
        if (b < 0) b = 0;
        if (b > FIELD_BLOCKS - 1) b = FIELD_BLOCKS - 1;
        return b[BLK_W-1:0];
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return KIND_FREE;
        if (r < 70) return KIND_ALLOC;
        if (r < 95) return KIND_QUERY;
        return KIND_UNKNOWN;
    endfunction

    initial begin
        int plan[10];
        int lim;
        int count;
        int burst;
        int rand_done;
        logic [BLK_W-1:0] blk;

        plan = '{64, 8191, 200, 1, 100, 4096, 33, 0, 160, 96};

        // every input known from time zero
        i_rst_n              <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        item_ch.valid        <= 1'b0;
        item_ch.kind         <= KIND_ALLOC;
        item_ch.block_number <= '0;
        shadow.set_total(TOTAL_RESET);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset value of total_blocks
        cfg_read_check(TOTAL_ADDR);

        // directed: empty disk reports full, rejected frees, first-fit order
        send_item(KIND_ALLOC, 12'hFFF);
        send_item(KIND_QUERY, 12'd0);
        send_item(KIND_FREE, 12'd0);
        send_item(KIND_FREE, 12'd4095);
        send_item(KIND_QUERY, 12'd4095);
        // blocks below the first allocatable one are accepted but never granted
        send_item(KIND_FREE, 12'd1);
        send_item(KIND_FREE, 12'd2);
        send_item(KIND_ALLOC, 12'd0);
        send_item(KIND_ALLOC, 12'd0);
        send_item(KIND_FREE, 12'd3);
        send_item(KIND_ALLOC, 12'hAAA);
        // unknown kind echoes the block with a reject
        send_item(KIND_UNKNOWN, 12'hFFF);
        send_item(KIND_QUERY, 12'd1);
        send_item(KIND_FREE, 12'hAAA);
        send_item(KIND_QUERY, 12'h555);

        // a small disk: frees and queries at or past the limit
        set_total_blocks(40);
        send_item(KIND_FREE, 12'd40);
        send_item(KIND_QUERY, 12'hAAA);
        send_item(KIND_FREE, 12'd39);
        send_item(KIND_ALLOC, 12'd0);

        // limit at the first allocatable block: allocation always full
        set_total_blocks(DEF_FIRST_ALLOCATABLE);
        send_item(KIND_FREE, 12'd2);
        send_item(KIND_ALLOC, 12'd0);

        // zero blocks: everything out of range
        set_total_blocks(0);
        send_item(KIND_FREE, 12'd1);
        send_item(KIND_QUERY, 12'd1);

        // random phases, most on small disks so allocation scans stay short
        rand_done = 0;
        foreach (plan[p]) begin
            set_total_blocks(plan[p]);
            lim   = (plan[p] > FIELD_BLOCKS) ? FIELD_BLOCKS : plan[p];
            count = (plan[p] >= FIELD_BLOCKS) ? 40 : 96;
            burst = (lim == 0) ? 0 : ((lim / 4 + 1 > 20) ? 20 : lim / 4 + 1);
            // long stall of the result side while requests keep coming
            if (p == 2) hold_req = 1'b1;
            for (int i = 0; i < count; i++) begin
                // idling modes: slow receiver, then slow sender, then none
                if (rand_done < 283) begin
                    send_idle_pct = 24;
                    recv_idle_pct = 79;
                end else if (rand_done < 566) begin
                    send_idle_pct = 79;
                    recv_idle_pct = 24;
                end else begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                // open each phase with frees so allocations have work to find
                if (i < burst) begin
                    blk = (lim > 1) ? BLK_W'($urandom_range(1, lim - 1)) : pick_block(lim);
                    send_item(KIND_FREE, blk);
                end else begin
                    send_item(pick_kind(), pick_block(lim));
                end
                rand_done++;
            end
        end

        wait_settled();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests over %0d block-count settings, %0d results checked",
                 items_sent, phases_run, shadow.checked);
        $display("allocations granted %0d, disk full %0d, rejected %0d",
                 shadow.granted, shadow.full_seen, shadow.rejected);
        if (shadow.mismatches == 0 && cfg_errors == 0 && shadow.outstanding() == 0) begin
            $display("status: pass");
        end else begin
            $display("mismatches %0d, register errors %0d", shadow.mismatches, cfg_errors);
            $display("status: fail");
        end
        $finish;
    end

endmodule
